### src/bb3_pkg.sv
package bb3_pkg;

    typedef logic [23:0] pixel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_MUL,
        ST_FIX
    } bb3_state_t;

    // Register indexes on the configuration port.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // floor(65536 / (2 * cnt)) for every neighbour count a window can produce.
    function automatic logic [15:0] recip_of(input logic [3:0] cnt);
        logic [15:0] r;
        unique case (cnt)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10922;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6553;
            4'd6:    r = 16'd5461;
            4'd7:    r = 16'd4681;
            4'd8:    r = 16'd4096;
            4'd9:    r = 16'd3640;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

### src/box_blur_3x3_rgb.sv
// Streaming 3x3 box blur for RGB frames in raster order. Each result is the
// mean of the in-frame pixels of its 3x3 neighbourhood, rounded half up, and
// leaves the block width+1 items after its own input pixel; flush items (or
// data items after the frame's last pixel) push the tail out, and frame_last
// marks the final result. Each pixel passes through accept with line-store
// read, window update and write-back and, if it produces a result,
// reciprocal multiply and rounding correction; a flush that has nothing to
// drain is dropped at accept. No new item is taken until the last one is
// through. A held result stalls only the correction step. The line stores
// need no clearing pass after reset. Writing either register restarts the
// frame.
module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);

    bb3_state_t state_reg, state_next;

    logic [10:0]   width_reg;
    logic [15:0]   height_reg;
    logic [AW-1:0] in_column_reg, in_column_next;
    logic [16:0]   in_row_reg, in_row_next;
    logic [AW-1:0] out_column_reg, out_column_next;
    logic [15:0]   out_row_reg, out_row_next;
    pixel_t        window_reg [3][3];
    pixel_t        win_shift  [3][3];
    pixel_t        view       [3][3];

    pixel_t        pix_reg;
    logic [12:0]   n_reg    [3];
    logic [3:0]    cnt_reg;
    logic          lastp_reg;
    logic [28:0]   prod_reg [3];

    logic          out_valid_reg;
    logic [7:0]    out_chan_reg [3];
    logic          frame_last_reg;

    logic          cfg_wr;
    logic [31:0]   w_wide;
    logic [EW-1:0] eff_w;
    logic [15:0]   eff_h;
    logic          row_active;
    logic          emit;
    logic          col_zero;
    logic          last_hit;
    logic [2:0]    rok, cok;
    logic [11:0]   sum_w [3];
    logic [3:0]    cnt_w;
    logic [12:0]   n_w [3];
    logic [AW:0]   col_inc;
    logic [AW:0]   ocol_inc;
    logic [4:0]    div_d;
    logic [7:0]    q0_w  [3];
    logic [12:0]   rem_w [3];
    logic [7:0]    q_w   [3];
    logic          take_pix;
    logic          load_out;
    pixel_t        older_q, newer_q;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_FRAME_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_FRAME_HEIGHT)
            begin
                height_reg <= pwdata[15:0];
            end
            else
            begin
                width_reg <= pwdata[10:0];
            end
        end
    end

    // Effective frame size.
    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            w_wide = 32'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_wide = 32'(MAX_WIDTH);
        end
        else
        begin
            w_wide = 32'(width_reg);
        end
    end

    assign eff_w      = EW'(w_wide);
    assign eff_h      = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign row_active = in_row_reg < {1'b0, eff_h};

    // Line stores, both addressed by the column of the item at hand.
    bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older_line (
        .clk   (clk),
        .we    (state_reg == ST_WIN),
        .waddr (in_column_reg),
        .wdata (newer_q),
        .raddr (in_column_reg),
        .rdata (older_q)
    );

    bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer_line (
        .clk   (clk),
        .we    (state_reg == ST_WIN),
        .waddr (in_column_reg),
        .wdata (pix_reg),
        .raddr (in_column_reg),
        .rdata (newer_q)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        take_pix   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // A flush while the frame is still arriving is dropped.
                if (in_valid && !(row_active && req_type))
                begin
                    take_pix   = 1'b1;
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                state_next = emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Window view and neighbour sums.
    assign emit     = (in_row_reg >= 17'd2) || (in_row_reg == 17'd1 && in_column_reg != '0);
    assign col_zero = (in_column_reg == '0);
    assign last_hit = (out_row_reg == eff_h - 16'd1)
                   && (32'(out_column_reg) == 32'(eff_w) - 32'd1);
    assign ocol_inc = {1'b0, out_column_reg} + 1'b1;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_shift[r][0] = window_reg[r][1];
            win_shift[r][1] = window_reg[r][2];
        end
        win_shift[0][2] = older_q;
        win_shift[1][2] = newer_q;
        win_shift[2][2] = pix_reg;

        // At the start of a row the result belongs to the previous row's last
        // column, which is still in the unshifted window.
        for (int r = 0; r < 3; r++)
        begin
            if (col_zero)
            begin
                view[r][0] = window_reg[r][1];
                view[r][1] = window_reg[r][2];
                view[r][2] = window_reg[r][2];
            end
            else
            begin
                view[r] = win_shift[r];
            end
        end

        rok[0] = out_row_reg != 16'd0;
        rok[1] = 1'b1;
        rok[2] = ({1'b0, out_row_reg} + 17'd1) < {1'b0, eff_h};
        cok[0] = out_column_reg != '0;
        cok[1] = 1'b1;
        cok[2] = !col_zero && (32'(ocol_inc) < 32'(eff_w));
    end

    always_comb
    begin
        cnt_w = 4'd0;
        for (int k = 0; k < 3; k++)
        begin
            sum_w[k] = 12'd0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rok[r] && cok[c])
                begin
                    cnt_w    = cnt_w + 4'd1;
                    sum_w[0] = sum_w[0] + 12'(view[r][c][23:16]);
                    sum_w[1] = sum_w[1] + 12'(view[r][c][15:8]);
                    sum_w[2] = sum_w[2] + 12'(view[r][c][7:0]);
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            n_w[k] = {sum_w[k], 1'b0} + 13'(cnt_w);
        end
    end

    // Position counters.
    assign col_inc = {1'b0, in_column_reg} + 1'b1;

    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (state_reg == ST_WIN)
        begin
            if (32'(col_inc) >= 32'(eff_w))
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + 17'd1;
            end
            else
            begin
                in_column_next = col_inc[AW-1:0];
            end
            if (emit)
            begin
                if (32'(ocol_inc) >= 32'(eff_w))
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_reg + 16'd1;
                end
                else
                begin
                    out_column_next = ocol_inc[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    window_reg[r][c] <= '0;
                end
            end
        end
        else if (cfg_wr || (state_reg == ST_WIN && emit && last_hit))
        begin
            // A register write or the frame's last result restarts the frame.
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    window_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
            if (state_reg == ST_WIN)
            begin
                window_reg <= win_shift;
            end
        end
    end

    // Datapath registers: capture, sums, reciprocal products.
    always_ff @(posedge clk)
    begin
        if (take_pix)
        begin
            pix_reg <= row_active ? {in_red, in_green, in_blue} : '0;
        end
        if (state_reg == ST_WIN)
        begin
            n_reg     <= n_w;
            cnt_reg   <= cnt_w;
            lastp_reg <= last_hit;
        end
        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= 29'(n_reg[k]) * 29'(recip_of(cnt_reg));
            end
        end
    end

    // The truncated reciprocal can be one short; one compare fixes it.
    assign div_d = {cnt_reg, 1'b0};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q0_w[k]  = prod_reg[k][23:16];
            rem_w[k] = n_reg[k] - (13'(q0_w[k]) * 13'(div_d));
            q_w[k]   = (rem_w[k] >= 13'(div_d)) ? q0_w[k] + 8'd1 : q0_w[k];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_chan_reg   <= q_w;
            frame_last_reg <= lastp_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_chan_reg[0];
    assign out_green  = out_chan_reg[1];
    assign out_blue   = out_chan_reg[2];
    assign frame_last = frame_last_reg;

    // A held result must keep the finished one waiting in the correction step.
    a_fix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX && out_valid_reg && !out_ready) |=> state_reg == ST_FIX)
        else $error("finished result was not held while the output was stalled");

    // The centre pixel is always counted, so the divisor is never zero.
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> cnt_reg != 4'd0)
        else $error("neighbour count is zero");

    // One correction step must be enough after the reciprocal multiply.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIX |-> (rem_w[0] < 13'({div_d, 1'b0}))
                             && (rem_w[1] < 13'({div_d, 1'b0}))
                             && (rem_w[2] < 13'({div_d, 1'b0})))
        else $error("rounding correction out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_column_reg) < 32'(eff_w))
        else $error("input column beyond the frame width");

endmodule

### src/bb3_ram.sv
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bb3_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int RANDOM_ITEMS = 400;
    localparam int WIDE_TAIL    = 12;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int PAUSE_FRAME  = 2;
    localparam int HOLD_FRAME   = 4;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [2:0] ADDR_FRAME_WIDTH  = {CFG_FRAME_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_FRAME_HEIGHT = {CFG_FRAME_HEIGHT, 2'b00};

    typedef enum {SET_WIDTH, SET_HEIGHT, SET_BOTH} cfg_sel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } rgb_result_t;

    class blur_scoreboard;
        logic [10:0] width_reg;
        logic [15:0] height_reg;
        pixel_t      older_line[MAX_WIDTH];
        pixel_t      newer_line[MAX_WIDTH];
        pixel_t      win[3][3];
        int          in_col;
        int          in_row;
        int          out_col;
        int          out_row;
        rgb_result_t expected_pixels[$];
        int          mismatches;

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mismatches = 0;
            foreach (older_line[i])
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (win[r, c])
                win[r][c] = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int active_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int active_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = value[10:0];
            else
                height_reg = value[15:0];
            restart_frame();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reg(logic idx, logic [31:0] value);
            if (idx == CFG_FRAME_WIDTH)
                compare_field("frame_width read", 32'(width_reg), value);
            else
                compare_field("frame_height read", 32'(height_reg), value);
        endfunction

        // Window columns lo, lo+1 and lo+2 sit left of, on and right of the result pixel.
        function rgb_result_t neighbor_mean(int lo);
            bit          row_ok[3];
            bit          col_ok[3];
            int          sum[3];
            int          count;
            int          w;
            int          h;
            rgb_result_t px;
            w = active_width();
            h = active_height();
            sum = '{0, 0, 0};
            count = 0;
            row_ok = '{out_row >= 1, 1'b1, out_row + 1 < h};
            col_ok = '{out_col >= 1, 1'b1, out_col + 1 < w};
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (row_ok[r] && col_ok[c] && lo + c <= 2)
                    begin
                        sum[0] += int'(win[r][lo + c][23:16]);
                        sum[1] += int'(win[r][lo + c][15:8]);
                        sum[2] += int'(win[r][lo + c][7:0]);
                        count++;
                    end
                end
            end
            px.red   = 8'((2 * sum[0] + count) / (2 * count));
            px.green = 8'((2 * sum[1] + count) / (2 * count));
            px.blue  = 8'((2 * sum[2] + count) / (2 * count));
            px.last  = (out_row == h - 1) && (out_col == w - 1);
            return px;
        endfunction

        function void take_pixel(logic kind, pixel_t px);
            int          w;
            int          h;
            int          col;
            bit          emit;
            pixel_t      data;
            rgb_result_t res;
            w = active_width();
            h = active_height();
            if (in_row < h)
            begin
                if (kind == REQ_FLUSH)
                    return;
                data = px;
            end
            else
                data = '0;
            col = in_col;
            emit = in_row >= 2 || (in_row == 1 && col >= 1);
            // A row's last result is formed before the shift pulls in the next row.
            if (emit && col == 0)
                res = neighbor_mean(1);
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = older_line[col];
            win[1][2] = newer_line[col];
            older_line[col] = newer_line[col];
            newer_line[col] = data;
            win[2][2] = data;
            if (emit && col != 0)
                res = neighbor_mean(0);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (!emit)
                return;
            expected_pixels.push_back(res);
            if (res.last)
                restart_frame();
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
            rgb_result_t want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: result expected none actual rgb %h %h %h last %b",
                         $time, r, g, b, last);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("out_red", 32'(want.red), 32'(r));
            compare_field("out_green", 32'(want.green), 32'(g));
            compare_field("out_blue", 32'(want.blue), 32'(b));
            compare_field("frame_last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        frame_last;

    blur_scoreboard blur_sb;
    bit             long_hold_req;
    int             burst_left;

    box_blur_3x3_rgb dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                blur_sb.write_reg(paddr[2], pwdata);
            if (in_valid && in_ready)
                blur_sb.take_pixel(req_type, {in_red, in_green, in_blue});
            if (out_valid && out_ready)
                blur_sb.check_pixel(out_red, out_green, out_blue, frame_last);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    // The result side alternates between always ready, random stalls, a fixed
    // stall pattern and a mostly stalled mode.
    initial
    begin : receiver
        int seg_len;
        int mode;
        int period;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            seg_len = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            period = $urandom_range(2, 5);
            for (int i = 0; i < seg_len; i++)
            begin
                if (long_hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    long_hold_req = 1'b0;
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (i % period) != 0;
                    default: out_ready <= $urandom_range(0, 7) == 0;
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic pixel_t rand_pixel();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic kind, input pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= kind;
        in_red <= px[23:16];
        in_green <= px[15:8];
        in_blue <= px[7:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (blur_sb.expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic [2:0] addr, input logic write, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (!write)
            blur_sb.check_reg(addr[2], prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int width_val, input int height_val, input cfg_sel_t sel);
        logic [31:0] word;
        wait_for_drain();
        if (sel != SET_HEIGHT)
        begin
            word = $urandom;
            word[10:0] = 11'(width_val);
            apb_access(ADDR_FRAME_WIDTH, 1'b1, word);
            apb_access(ADDR_FRAME_WIDTH, 1'b0, '0);
        end
        if (sel != SET_WIDTH)
        begin
            word = $urandom;
            word[15:0] = 16'(height_val);
            apb_access(ADDR_FRAME_HEIGHT, 1'b1, word);
            apb_access(ADDR_FRAME_HEIGHT, 1'b0, '0);
        end
    endtask

    // Sends n_send pixels with stray flushes mixed in, then a tail of flushes
    // and ignored data items that drains the pending results.
    task automatic run_frame(input int n_send, input int tail, input int pause_at,
                             inout int items);
        for (int p = 0; p < n_send; p++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(REQ_FLUSH, rand_pixel());
            if (p == pause_at)
                wait_for_drain();
            send_item(REQ_PIXEL, rand_pixel());
        end
        for (int t = 0; t < tail; t++)
            send_item($urandom_range(0, 1) ? REQ_FLUSH : REQ_PIXEL, rand_pixel());
        items += n_send + tail;
    endtask

    initial
    begin : stimulus
        pixel_t corner_mix[9];
        int     items;
        int     frame_idx;
        int     w;
        int     h;
        int     n_px;
        int     sel;
        bit     broken;
        bit     force_write;
        blur_sb = new();
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        req_type <= REQ_PIXEL;
        in_red <= '0;
        in_green <= '0;
        in_blue <= '0;
        burst_left = 0;
        long_hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Under the reset geometry: an early flush, then two pixels that the
        // register write below throws away.
        send_item(REQ_FLUSH, 24'h000000);
        send_item(REQ_PIXEL, 24'hFFFFFF);
        send_item(REQ_PIXEL, 24'h000000);
        configure(3, 3, SET_BOTH);

        // A 3x3 frame covers corners, edges and the full nine-pixel window.
        corner_mix = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
                       24'h010203, 24'h000001, 24'hFEFEFE, 24'h7F807F};
        for (int i = 0; i < 9; i++)
        begin
            send_item(REQ_PIXEL, corner_mix[i]);
            if (i == 3)
                send_item(REQ_FLUSH, 24'hFFFFFF);
        end
        send_item(REQ_PIXEL, 24'hABCDEF);
        repeat (3) send_item(REQ_FLUSH, 24'h000000);
        send_item(REQ_FLUSH, 24'h000000);

        // Zero width and height both act as one.
        configure(0, 0, SET_BOTH);
        send_item(REQ_PIXEL, 24'h808080);
        send_item(REQ_FLUSH, 24'hFFFFFF);
        send_item(REQ_PIXEL, rand_pixel());

        configure(MAX_WIDTH, 65535, SET_BOTH);
        repeat (3) send_item(REQ_PIXEL, rand_pixel());

        // A width above the line store size acts as the full store. The first
        // results of this one-row frame come out, then the next register write
        // abandons the rest.
        items = 0;
        configure(2047, 1, SET_BOTH);
        run_frame(MAX_WIDTH, WIDE_TAIL, -1, items);

        items = 0;
        frame_idx = 0;
        force_write = 1'b1;
        while (items < RANDOM_ITEMS || frame_idx <= HOLD_FRAME)
        begin
            if (frame_idx == HOLD_FRAME)
                configure(16, 6, SET_BOTH);
            else if (force_write || $urandom_range(0, 2) != 0)
            begin
                sel = $urandom_range(0, 9);
                w = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                sel = $urandom_range(0, 9);
                h = (sel == 0) ? 0 : (sel < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
                configure(w, h, force_write ? SET_BOTH : cfg_sel_t'($urandom_range(0, 2)));
            end
            force_write = 1'b0;
            n_px = blur_sb.active_width() * blur_sb.active_height();
            broken = frame_idx > HOLD_FRAME && $urandom_range(0, 9) == 0;
            if (frame_idx == HOLD_FRAME)
                long_hold_req = 1'b1;
            if (broken)
            begin
                // A cut-off frame is abandoned by the next register write.
                run_frame($urandom_range(0, n_px - 1), 0, -1, items);
                force_write = 1'b1;
            end
            else
                run_frame(n_px, blur_sb.active_width() + 1,
                          (frame_idx == PAUSE_FRAME) ? n_px / 2 : -1, items);
            if ($urandom_range(0, 4) == 0)
                send_item(REQ_FLUSH, rand_pixel());
            frame_idx++;
        end

        wait_for_drain();
        if (blur_sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
